FILE: rtl/core/tts_pkg.sv
package tts_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  localparam logic [1:0] KIND_WORD  = 2'd0;
  localparam logic [1:0] KIND_QUOTE = 2'd1;
  localparam logic [1:0] KIND_PUNCT = 2'd2;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [4:0] {
    MODE_SKIP    = 5'b00001,
    MODE_SLASH   = 5'b00010,
    MODE_COMMENT = 5'b00100,
    MODE_QUOTE   = 5'b01000,
    MODE_WORD    = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [7:0] tok_byte;
    logic       byte_valid;
    logic       tok_last;
    logic [1:0] tok_kind;
    logic       stream_end;
    logic       run_last;
  } res_t;

  function automatic res_t mk_res(input logic [7:0] b, input logic valid,
                                  input logic last, input logic [1:0] kind,
                                  input logic fin);
    res_t r;
    r.tok_byte   = b;
    r.byte_valid = valid;
    r.tok_last   = last;
    r.tok_kind   = kind;
    r.stream_end = fin;
    r.run_last   = 1'b0;
    return r;
  endfunction

  function automatic res_t end_marker();
    return mk_res(CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_RPAREN) ||
           (c == CH_LPAREN) || (c == CH_SQUOTE) || (c == CH_COLON);
  endfunction

endpackage

FILE: rtl/core/tts_ifs.sv
interface tts_in_if;
  import tts_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface tts_out_if;
  import tts_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] tok_byte;
  logic       byte_valid;
  logic       tok_last;
  logic [1:0] tok_kind;
  logic       stream_end;
  logic       run_last;

  modport source (output valid, output tok_byte, output byte_valid, output tok_last,
                  output tok_kind, output stream_end, output run_last, input ready);
  modport sink   (input valid, input tok_byte, input byte_valid, input tok_last,
                  input tok_kind, input stream_end, input run_last, output ready);
endinterface

FILE: rtl/core/text_token_splitter_core.sv
// Text token splitter.
// in_chan carries one text byte per request (ch); a zero byte ends the text.
// out_tok carries token results: one token byte per request, with tok_last on
// the last byte of a token, tok_kind, an empty-token result for "" and a
// stream_end marker. run_last flags the last result caused by one input byte.
// cfg_we/cfg_wdata write high_bytes_as_space; write it only while idle.
// Each input byte yields zero, one or two results, written to the result queue
// as the byte is accepted. Input and output each pass one request per cycle
// unless stalled; a byte that ends a word with punctuation or end of text, or
// a string with end of text, yields two results and takes two output requests.
// A four-entry result queue sits between the mode logic and the output;
// in_chan.ready is high while at least two queue entries are free, so a
// stalled receiver stops the input once three or more results wait, with at
// most four queued. Reset (synchronous, rst_n low) empties the queue, returns
// to whitespace skipping with nothing held, and clears high_bytes_as_space.
module text_token_splitter_core (
  input  logic      clk,
  input  logic      rst_n,
  tts_in_if.sink    in_chan,
  tts_out_if.source out_tok,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import tts_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  logic             hi_space_r;
  mode_t            mode_r, mode_nxt;
  logic [7:0]       held_byte_r, held_byte_nxt;
  logic             held_valid_r, held_valid_nxt;

  res_t             fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;

  logic [7:0]       c;
  logic             c_space, c_punct, accept, pop;
  logic [1:0]       n_res, n_raw, w_n;
  res_t             r0, r1, raw0, raw1, w_r0, w_r1;
  mode_t            w_mode;
  logic [7:0]       w_hb;

  assign c       = in_chan.ch;
  assign c_punct = is_punct(c);
  assign c_space = (c <= CH_SPACE) || (hi_space_r && c[7]);
  assign accept  = in_chan.valid && in_chan.ready;
  assign pop     = out_tok.valid && out_tok.ready;

  assign in_chan.ready = (count_r <= (PTR_W+1)'(FIFO_DEPTH - 2));

  // word continuation, shared by word mode and a lone slash
  always_comb begin
    w_r0   = mk_res(held_byte_r, 1'b1, 1'b1, KIND_WORD, 1'b0);
    w_r1   = end_marker();
    w_n    = 2'd1;
    w_mode = MODE_SKIP;
    w_hb   = held_byte_r;
    if (c_punct) begin
      w_r1 = mk_res(c, 1'b1, 1'b1, KIND_PUNCT, 1'b0);
      w_n  = 2'd2;
    end else if (c_space) begin
      if (c == CH_NUL) w_n = 2'd2;
    end else begin
      w_r0.tok_last = 1'b0;
      w_mode        = MODE_WORD;
      w_hb          = c;
    end
  end

  always_comb begin
    mode_nxt       = mode_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    n_raw          = 2'd0;
    raw0           = end_marker();
    raw1           = end_marker();
    case (mode_r)
      MODE_SLASH, MODE_WORD: begin
        if (mode_r == MODE_SLASH && c == CH_SLASH) begin
          mode_nxt       = MODE_COMMENT;
          held_valid_nxt = 1'b0;
        end else begin
          n_raw          = w_n;
          raw0           = w_r0;
          raw1           = w_r1;
          mode_nxt       = w_mode;
          held_byte_nxt  = w_hb;
          held_valid_nxt = (w_mode == MODE_WORD);
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NUL) begin
          n_raw    = 2'd1;
          mode_nxt = MODE_SKIP;
        end else if (c == CH_LF) begin
          mode_nxt = MODE_SKIP;
        end
      end
      MODE_QUOTE: begin
        if (c == CH_DQUOTE || c == CH_NUL) begin
          raw0 = held_valid_r ? mk_res(held_byte_r, 1'b1, 1'b1, KIND_QUOTE, 1'b0)
                              : mk_res(CH_NUL, 1'b0, 1'b1, KIND_QUOTE, 1'b0);
          n_raw          = (c == CH_NUL) ? 2'd2 : 2'd1;
          mode_nxt       = MODE_SKIP;
          held_valid_nxt = 1'b0;
        end else begin
          raw0           = mk_res(held_byte_r, 1'b1, 1'b0, KIND_QUOTE, 1'b0);
          n_raw          = held_valid_r ? 2'd1 : 2'd0;
          held_byte_nxt  = c;
          held_valid_nxt = 1'b1;
        end
      end
      default: begin
        mode_nxt       = MODE_SKIP;
        held_valid_nxt = 1'b0;
        if (c == CH_NUL) begin
          n_raw = 2'd1;
        end else if (c_space) begin
          n_raw = 2'd0;
        end else if (c == CH_SLASH) begin
          mode_nxt       = MODE_SLASH;
          held_byte_nxt  = c;
          held_valid_nxt = 1'b1;
        end else if (c == CH_DQUOTE) begin
          mode_nxt = MODE_QUOTE;
        end else if (c_punct) begin
          n_raw = 2'd1;
          raw0  = mk_res(c, 1'b1, 1'b1, KIND_PUNCT, 1'b0);
        end else begin
          mode_nxt       = MODE_WORD;
          held_byte_nxt  = c;
          held_valid_nxt = 1'b1;
        end
      end
    endcase
  end

  // mark the last result of this byte
  always_comb begin
    r0 = raw0;
    r1 = raw1;
    r0.run_last = (n_raw == 2'd1);
    r1.run_last = 1'b1;
    n_res = accept ? n_raw : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_space_r   <= 1'b0;
      mode_r       <= MODE_SKIP;
      held_byte_r  <= CH_NUL;
      held_valid_r <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
    end else begin
      if (cfg_we) hi_space_r <= cfg_wdata;
      if (accept) begin
        mode_r       <= mode_nxt;
        held_byte_r  <= held_byte_nxt;
        held_valid_r <= held_valid_nxt;
      end
      wr_ptr_r <= wr_ptr_r + PTR_W'(n_res);
      if (pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r  <= count_r + (PTR_W+1)'(n_res) - (PTR_W+1)'(pop);
    end
  end

  // result queue payload, no reset
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) fifo_r[wr_ptr_r] <= r0;
    if (n_res == 2'd2) fifo_r[wr_ptr_r + PTR_W'(1)] <= r1;
  end

  always_comb begin
    out_tok.valid      = (count_r != '0);
    out_tok.tok_byte   = fifo_r[rd_ptr_r].tok_byte;
    out_tok.byte_valid = fifo_r[rd_ptr_r].byte_valid;
    out_tok.tok_last   = fifo_r[rd_ptr_r].tok_last;
    out_tok.tok_kind   = fifo_r[rd_ptr_r].tok_kind;
    out_tok.stream_end = fifo_r[rd_ptr_r].stream_end;
    out_tok.run_last   = fifo_r[rd_ptr_r].run_last;
  end

endmodule

FILE: rtl/core/tts_checker.sv
module tts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       byte_valid,
  input logic       tok_last,
  input logic [1:0] tok_kind,
  input logic       stream_end,
  input logic       run_last
);
  import tts_pkg::*;

  // hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stream_end |-> !byte_valid && !tok_last && run_last)
    else $error("malformed end marker");

  a_empty_tok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid && !stream_end |-> tok_last && tok_kind == KIND_QUOTE)
    else $error("empty result that is not an empty string");

  a_punct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tok_kind == KIND_PUNCT |-> tok_last && byte_valid && !stream_end)
    else $error("punctuation token not a single byte");

endmodule

bind text_token_splitter_core tts_checker u_tts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_tok.valid),
  .out_ready  (out_tok.ready),
  .byte_valid (out_tok.byte_valid),
  .tok_last   (out_tok.tok_last),
  .tok_kind   (out_tok.tok_kind),
  .stream_end (out_tok.stream_end),
  .run_last   (out_tok.run_last)
);

FILE: tb/text_token_splitter_core_tb.sv
module text_token_splitter_core_tb;
  import tts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          PHASE_ITEMS = 300;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          HOLD_AFTER = 150;
  localparam int          HOLD_CYCLES = 300;
  localparam int          END_WAIT = 3000;

  localparam res_t RES_NONE = '0;
  localparam res_t RES_END = '{tok_byte: CH_NUL, byte_valid: 1'b0, tok_last: 1'b0,
                               tok_kind: KIND_WORD, stream_end: 1'b1, run_last: 1'b1};
  localparam res_t RES_EMPTY = '{tok_byte: CH_NUL, byte_valid: 1'b0, tok_last: 1'b1,
                                 tok_kind: KIND_QUOTE, stream_end: 1'b0, run_last: 1'b1};

  typedef enum logic {ROW_CH, ROW_CFG} row_op_t;
  // PRED: take the predictor's results; NONE/ONE: typed expectation
  typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_ONE} row_exp_t;

  typedef struct {
    row_op_t    op;
    logic [7:0] val;
    row_exp_t   how;
    res_t       res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic cfg_wdata;

  tts_in_if  in_if ();
  tts_out_if out_if ();

  text_token_splitter_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_tok  (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predictor state
  mode_t      tok_mode = MODE_SKIP;
  logic [7:0] tok_held = 8'h00;
  logic       tok_held_v = 1'b0;
  logic       space_hi = 1'b0;
  res_t       step_q[$];

  res_t       tok_exp_q[$];
  row_exp_t   item_how_q[$];
  res_t       item_res_q[$];
  logic [7:0] text_q[$];
  stim_row_t  dir_rows[$];

  int          mismatches = 0;
  int          results_seen = 0;
  bit          idle_en = 1'b1;
  bit          held_off = 1'b0;
  int unsigned cycle_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("text_token_splitter_core test failed");
    $finish;
  end

  function automatic logic punct_byte(input logic [7:0] c);
    return c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN || c == CH_RPAREN ||
           c == CH_SQUOTE || c == CH_COLON;
  endfunction

  function automatic logic gap_byte(input logic [7:0] c);
    return (c <= CH_SPACE) || (space_hi && c[7]);
  endfunction

  function automatic void add_res(input logic [7:0] b, input logic bv, input logic last,
                                  input logic [1:0] kind, input logic fin);
    res_t r;
    r.tok_byte   = b;
    r.byte_valid = bv;
    r.tok_last   = last;
    r.tok_kind   = kind;
    r.stream_end = fin;
    r.run_last   = 1'b0;
    step_q.push_back(r);
  endfunction

  // advance the tokenizer by one byte, leaving its results in step_q
  function automatic void split_byte(input logic [7:0] c);
    step_q.delete();
    case (tok_mode)
      MODE_SLASH, MODE_WORD: begin
        if (tok_mode == MODE_SLASH && c == CH_SLASH) begin
          tok_mode = MODE_COMMENT;
          tok_held_v = 1'b0;
        end else if (punct_byte(c)) begin
          add_res(tok_held, 1'b1, 1'b1, KIND_WORD, 1'b0);
          add_res(c, 1'b1, 1'b1, KIND_PUNCT, 1'b0);
          tok_mode = MODE_SKIP;
          tok_held_v = 1'b0;
        end else if (gap_byte(c)) begin
          add_res(tok_held, 1'b1, 1'b1, KIND_WORD, 1'b0);
          if (c == CH_NUL) add_res(CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
          tok_mode = MODE_SKIP;
          tok_held_v = 1'b0;
        end else begin
          // a lone slash becomes the first word byte here
          add_res(tok_held, 1'b1, 1'b0, KIND_WORD, 1'b0);
          tok_held = c;
          tok_held_v = 1'b1;
          tok_mode = MODE_WORD;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NUL) begin
          add_res(CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
          tok_mode = MODE_SKIP;
        end else if (c == CH_LF) begin
          tok_mode = MODE_SKIP;
        end
      end
      MODE_QUOTE: begin
        if (c == CH_DQUOTE || c == CH_NUL) begin
          if (tok_held_v) add_res(tok_held, 1'b1, 1'b1, KIND_QUOTE, 1'b0);
          else add_res(CH_NUL, 1'b0, 1'b1, KIND_QUOTE, 1'b0);
          if (c == CH_NUL) add_res(CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
          tok_mode = MODE_SKIP;
          tok_held_v = 1'b0;
        end else begin
          if (tok_held_v) add_res(tok_held, 1'b1, 1'b0, KIND_QUOTE, 1'b0);
          tok_held = c;
          tok_held_v = 1'b1;
        end
      end
      default: begin
        tok_mode = MODE_SKIP;
        tok_held_v = 1'b0;
        if (c == CH_NUL) begin
          add_res(CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
        end else if (gap_byte(c)) begin
        end else if (c == CH_SLASH) begin
          tok_mode = MODE_SLASH;
          tok_held = c;
          tok_held_v = 1'b1;
        end else if (c == CH_DQUOTE) begin
          tok_mode = MODE_QUOTE;
        end else if (punct_byte(c)) begin
          add_res(c, 1'b1, 1'b1, KIND_PUNCT, 1'b0);
        end else begin
          tok_mode = MODE_WORD;
          tok_held = c;
          tok_held_v = 1'b1;
        end
      end
    endcase
    if (step_q.size() > 0) step_q[step_q.size() - 1].run_last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
               results_seen, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // input side: track config writes and predict each accepted request
  always @(posedge clk) begin
    row_exp_t how;
    res_t     typed;
    if (!rst_n) begin
      tok_mode = MODE_SKIP;
      tok_held = 8'h00;
      tok_held_v = 1'b0;
      space_hi = 1'b0;
    end else begin
      if (cfg_we) space_hi = cfg_wdata;
      if (in_if.valid && in_if.ready) begin
        split_byte(in_if.ch);
        how = item_how_q.pop_front();
        typed = item_res_q.pop_front();
        case (how)
          EXP_PRED: foreach (step_q[i]) tok_exp_q.push_back(step_q[i]);
          EXP_ONE:  tok_exp_q.push_back(typed);
          default: begin
          end
        endcase
      end
    end
  end

  // result side
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (tok_exp_q.size() == 0) begin
        report_mismatch("result with nothing pending, tok_byte", out_if.tok_byte, 8'h00);
      end else begin
        want = tok_exp_q.pop_front();
        check_field("tok_byte", out_if.tok_byte, want.tok_byte);
        check_field("byte_valid", 8'(out_if.byte_valid), 8'(want.byte_valid));
        check_field("tok_last", 8'(out_if.tok_last), 8'(want.tok_last));
        check_field("tok_kind", 8'(out_if.tok_kind), 8'(want.tok_kind));
        check_field("stream_end", 8'(out_if.stream_end), 8'(want.stream_end));
        check_field("run_last", 8'(out_if.run_last), 8'(want.run_last));
      end
    end
  end

  initial begin : result_sink
    int k;
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!held_off && results_seen >= HOLD_AFTER) begin
        // long hold-off: the result queue fills and the input backs up
        held_off = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, 7);
        out_if.ready <= 1'b0;
        repeat (k) @(posedge clk);
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input row_exp_t how, input res_t typed);
    int k;
    item_how_q.push_back(how);
    item_res_q.push_back(typed);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, 7);
      in_if.valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic write_space_hi(input logic v);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (tok_exp_q.size() != 0) @(posedge clk);
    // a byte with no result may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void add_row(input row_op_t op, input logic [7:0] v,
                                  input row_exp_t how, input res_t r);
    stim_row_t row;
    row.op = op;
    row.val = v;
    row.how = how;
    row.res = r;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(0, 5))
      0: return CH_LBRACE;
      1: return CH_RBRACE;
      2: return CH_LPAREN;
      3: return CH_RPAREN;
      4: return CH_SQUOTE;
      default: return CH_COLON;
    endcase
  endfunction

  function automatic logic [7:0] word_byte(input logic hi, input logic first);
    logic [7:0] b;
    do b = hi ? 8'($urandom_range(8'h21, 8'h7f)) : 8'($urandom_range(8'h21, 8'hff));
    while (punct_byte(b) || (first && (b == CH_DQUOTE || b == CH_SLASH)));
    return b;
  endfunction

  function automatic logic [7:0] blank_byte(input logic hi);
    if (hi && $urandom_range(0, 2) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(1, 32));
  endfunction

  // append one mostly well-formed piece of text to text_q
  function automatic void make_seq(input logic hi);
    int kind;
    int len;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    if (kind < 30) begin
      text_q.push_back(word_byte(hi, 1'b1));
      repeat (len) text_q.push_back(word_byte(hi, 1'b0));
    end else if (kind < 45) begin
      text_q.push_back(CH_DQUOTE);
      repeat (len) begin
        do b = 8'($urandom_range(1, 255)); while (b == CH_DQUOTE);
        text_q.push_back(b);
      end
      text_q.push_back($urandom_range(0, 9) == 0 ? CH_NUL : CH_DQUOTE);
    end else if (kind < 60) begin
      text_q.push_back(pick_punct());
    end else if (kind < 68) begin
      text_q.push_back(CH_SLASH);
      text_q.push_back(CH_SLASH);
      repeat (len) begin
        do b = 8'($urandom_range(1, 255)); while (b == CH_LF);
        text_q.push_back(b);
      end
      text_q.push_back($urandom_range(0, 9) == 0 ? CH_NUL : CH_LF);
    end else if (kind < 75) begin
      text_q.push_back(CH_SLASH);
      if ($urandom_range(0, 3) == 0) begin
        text_q.push_back(pick_punct());
      end else begin
        text_q.push_back(word_byte(hi, 1'b1));
        repeat (len) text_q.push_back(word_byte(hi, 1'b0));
      end
    end else if (kind < 80) begin
      text_q.push_back(CH_NUL);
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(blank_byte(hi));
    end else begin
      repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
    end
    if (kind < 30 || (kind >= 68 && kind < 75))
      if ($urandom_range(0, 9) < 6) text_q.push_back(blank_byte(hi));
  endfunction

  initial begin
    logic phase_hi [4];
    int   sent;
    int   waited;
    phase_hi = '{1'b1, 1'b0, 1'b1, 1'b0};
    in_if.valid <= 1'b0;
    in_if.ch <= 8'h00;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(ROW_CH, CH_NUL, EXP_ONE, RES_END);
    add_row(ROW_CH, CH_LPAREN, EXP_ONE, {CH_LPAREN, 1'b1, 1'b1, KIND_PUNCT, 1'b0, 1'b1});
    add_row(ROW_CH, CH_SPACE, EXP_NONE, RES_NONE);
    add_row(ROW_CH, 8'h61, EXP_NONE, RES_NONE);
    add_row(ROW_CH, CH_DQUOTE, EXP_PRED, RES_NONE);
    add_row(ROW_CH, CH_SLASH, EXP_PRED, RES_NONE);
    add_row(ROW_CH, CH_COLON, EXP_PRED, RES_NONE);
    add_row(ROW_CH, CH_DQUOTE, EXP_NONE, RES_NONE);
    add_row(ROW_CH, CH_DQUOTE, EXP_ONE, RES_EMPTY);
    add_row(ROW_CH, CH_DQUOTE, EXP_NONE, RES_NONE);
    add_row(ROW_CH, 8'hff, EXP_PRED, RES_NONE);
    add_row(ROW_CH, CH_NUL, EXP_PRED, RES_NONE);
    add_row(ROW_CH, CH_SLASH, EXP_PRED, RES_NONE);
    add_row(ROW_CH, CH_SLASH, EXP_PRED, RES_NONE);
    add_row(ROW_CH, 8'h80, EXP_PRED, RES_NONE);
    add_row(ROW_CH, CH_NUL, EXP_ONE, RES_END);
    add_row(ROW_CH, CH_LBRACE, EXP_ONE, {CH_LBRACE, 1'b1, 1'b1, KIND_PUNCT, 1'b0, 1'b1});
    add_row(ROW_CH, CH_SLASH, EXP_PRED, RES_NONE);
    add_row(ROW_CH, 8'hff, EXP_PRED, RES_NONE);
    add_row(ROW_CH, CH_RBRACE, EXP_PRED, RES_NONE);
    add_row(ROW_CFG, 8'h01, EXP_NONE, RES_NONE);
    add_row(ROW_CH, 8'hff, EXP_NONE, RES_NONE);
    add_row(ROW_CH, 8'h71, EXP_NONE, RES_NONE);
    add_row(ROW_CH, 8'h80, EXP_PRED, RES_NONE);
    add_row(ROW_CH, CH_RPAREN, EXP_ONE, {CH_RPAREN, 1'b1, 1'b1, KIND_PUNCT, 1'b0, 1'b1});

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CFG) write_space_hi(dir_rows[i].val[0]);
      else send_byte(dir_rows[i].val, dir_rows[i].how, dir_rows[i].res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) write_space_hi(phase_hi[ph]);
      if (ph == 3) idle_en = 1'b0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        make_seq(phase_hi[ph]);
        while (text_q.size() != 0) begin
          send_byte(text_q.pop_front(), EXP_PRED, RES_NONE);
          sent++;
        end
      end
    end

    in_if.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (tok_exp_q.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tok_exp_q.size() != 0)
      report_mismatch("results never delivered, count", 8'(tok_exp_q.size()), 8'h00);

    if (mismatches == 0) begin
      $display("text_token_splitter_core test passed");
    end else begin
      $display("text_token_splitter_core test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/tts_pkg.sv
rtl/core/tts_ifs.sv
rtl/core/text_token_splitter_core.sv
rtl/core/tts_checker.sv
tb/text_token_splitter_core_tb.sv
